// ===== design/adc_bay_tamper_detector_macros.svh =====
// assertion macros for the bay tamper detector
// used by the top level only, no other dependencies
`ifndef ADC_BAY_TAMPER_DETECTOR_MACROS_SVH
`define ADC_BAY_TAMPER_DETECTOR_MACROS_SVH

// same-cycle implication
`define ABTD_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);

// next-cycle implication
`define ABTD_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);

`endif

// ===== design/abtd_pkg.sv =====
// shared types and constants for the bay tamper detector
// no dependencies
`timescale 1ns / 1ps

package abtd_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int CFG_IDX_BITS    = 3;
	localparam int NUM_LEVELS      = 7;
	localparam int CODE_BITS       = 3;

	// drive checks enabled in this build
	localparam logic CHECK_SSD = 1'b1;
	localparam logic CHECK_BAY = 1'b1;
	localparam logic [CODE_BITS-1:0] ENABLED_MASK = {1'b1, CHECK_SSD, CHECK_BAY};

	typedef enum logic [1:0] {
		PS_OTHER = 2'd0,
		PS_S5    = 2'd1,
		PS_S3    = 2'd2
	} pwr_state_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TOLERANCE = 3'd0,
		REG_LEVEL0    = 3'd1,
		REG_LEVEL1    = 3'd2,
		REG_LEVEL2    = 3'd3,
		REG_LEVEL3    = 3'd4,
		REG_LEVEL4    = 3'd5,
		REG_LEVEL5    = 3'd6,
		REG_LEVEL6    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                 match;
		logic [CODE_BITS-1:0] code;
	} quant_res_t;

	typedef struct packed {
		logic                 change;
		logic [CODE_BITS-1:0] removed;
		logic [CODE_BITS-1:0] present;
	} result_t;

endpackage

// ===== design/abtd_cfg_regs.sv =====
// configuration registers: match tolerance and the seven quantiser levels
// depends on abtd_pkg
`timescale 1ns / 1ps

module abtd_cfg_regs import abtd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]  cfg_data,
	output logic [SAMPLE_BITS-1:0]  tolerance,
	output logic [SAMPLE_BITS-1:0]  levels [NUM_LEVELS]
);

	logic [SAMPLE_BITS-1:0] tol_q;
	logic [SAMPLE_BITS-1:0] lvl_q [NUM_LEVELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
			for (int k = 0; k < NUM_LEVELS; k++) begin
				lvl_q[k] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_TOLERANCE) begin
				tol_q <= cfg_data;
			end else begin
				// level registers follow the tolerance register
				lvl_q[cfg_index - CFG_IDX_BITS'(REG_LEVEL0)] <= cfg_data;
			end
		end
	end

	assign tolerance = tol_q;
	assign levels    = lvl_q;

endmodule

// ===== design/abtd_quant.sv =====
// sample classifier: distance check against the accepted sample and
// descending-threshold quantiser; depends on abtd_pkg
`timescale 1ns / 1ps

module abtd_quant import abtd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0] accepted,
	input  logic [SAMPLE_BITS-1:0] tolerance,
	input  logic [SAMPLE_BITS-1:0] levels [NUM_LEVELS],
	output quant_res_t             qres
);

	logic [SAMPLE_BITS-1:0] diff;
	logic [CODE_BITS-1:0]   code;

	assign diff = (sample > accepted) ? (sample - accepted) : (accepted - sample);

	// first level the sample reaches wins, none reached gives the top code
	always_comb begin
		code = CODE_BITS'(NUM_LEVELS);
		for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
			if (sample >= levels[k]) begin
				code = CODE_BITS'(k);
			end
		end
	end

	assign qres.match = diff < tolerance;
	assign qres.code  = code;

endmodule

// ===== design/abtd_core.sv =====
// debounce and tamper state with the result register
// depends on abtd_pkg
`timescale 1ns / 1ps

module abtd_core import abtd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   proc,
	input  logic                   out_ready,
	input  logic                   sample_valid,
	input  logic [SAMPLE_BITS-1:0] sample_value,
	input  logic [1:0]             power_state,
	input  logic                   ec_on,
	input  quant_res_t             qres,
	output logic [SAMPLE_BITS-1:0] accepted,
	output logic                   out_valid,
	output result_t                res
);

	logic [SAMPLE_BITS-1:0] acc_q, acc_n;
	logic [CODE_BITS-1:0]   cur_q, cur_n;
	logic [CODE_BITS-1:0]   prev_q, prev_n;
	logic [CODE_BITS-1:0]   cand_q, cand_n;
	logic [CODE_BITS-1:0]   rem_q, rem_n;
	logic                   pend_q, pend_n;
	logic                   out_valid_q;
	result_t                res_q, res_n;
	logic                   s5_on, s3;
	logic                   change;

	always_comb begin
		s5_on  = 1'b0;
		s3     = 1'b0;
		case (power_state)
			PS_S5:   s5_on = ec_on;
			PS_S3:   s3    = 1'b1;
			default: ;
		endcase

		acc_n  = acc_q;
		cur_n  = cur_q;
		prev_n = prev_q;
		cand_n = cand_q;
		pend_n = pend_q;
		rem_n  = rem_q;
		change = 1'b0;

		if (s5_on || s3) begin
			if (!sample_valid || qres.match) begin
				pend_n = 1'b0;
			end else if (pend_q) begin
				pend_n = 1'b0;
				// second code equal to the candidate: take it
				if (cand_q == qres.code) begin
					change = 1'b1;
					acc_n  = sample_value;
					prev_n = cur_q;
					cur_n  = cand_q;
				end
			end else begin
				cand_n = qres.code;
				pend_n = 1'b1;
			end
		end

		if (s5_on) begin
			rem_n = '0;
		end else if (s3 && change) begin
			rem_n = rem_q | (prev_n & ~cur_n & ENABLED_MASK);
		end

		res_n.change  = change;
		res_n.removed = rem_n;
		res_n.present = cur_n & ENABLED_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			cand_q      <= '0;
			pend_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (proc) begin
			acc_q       <= acc_n;
			cur_q       <= cur_n;
			prev_q      <= prev_n;
			cand_q      <= cand_n;
			pend_q      <= pend_n;
			rem_q       <= rem_n;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_q <= res_n;
		end
	end

	assign accepted  = acc_q;
	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

// ===== design/adc_bay_tamper_detector.sv =====
// channel    handshake              payload
// input      in_valid / in_ready    sample_valid, sample_value, power_state, ec_on
// result     out_valid / out_ready  change_detected, *_removed, *_present
// config     cfg_we                 cfg_index, cfg_data
//
// one tick per cycle sustained unless the result stalls; the result is registered
// through the input register and the result register around the classifier.
// reset clears all debounce, tamper and config state at once.
// a stalled result holds in its register while one more tick waits in the
// input register; in_ready drops only when both are full and out_ready is low.
// top level: input register, config, classifier and state core
// depends on abtd_pkg and adc_bay_tamper_detector_macros.svh
`timescale 1ns / 1ps
`include "adc_bay_tamper_detector_macros.svh"

module adc_bay_tamper_detector import abtd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]  cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    sample_valid,
	input  logic [SAMPLE_BITS-1:0]  sample_value,
	input  logic [1:0]              power_state,
	input  logic                    ec_on,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    change_detected,
	output logic                    hdd_removed,
	output logic                    ssd_removed,
	output logic                    bay_removed,
	output logic                    hdd_present,
	output logic                    ssd_present,
	output logic                    bay_present
);

	logic                   valid_s1;
	logic                   sample_valid_s1;
	logic [SAMPLE_BITS-1:0] sample_value_s1;
	logic [1:0]             power_state_s1;
	logic                   ec_on_s1;
	logic                   advance, proc;
	logic [SAMPLE_BITS-1:0] tolerance;
	logic [SAMPLE_BITS-1:0] levels [NUM_LEVELS];
	logic [SAMPLE_BITS-1:0] accepted;
	quant_res_t             qres;
	result_t                res;

	assign advance  = !out_valid || out_ready;
	assign proc     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_valid_s1 <= sample_valid;
			sample_value_s1 <= sample_value;
			power_state_s1  <= power_state;
			ec_on_s1        <= ec_on;
		end
	end

	abtd_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tolerance (tolerance),
		.levels    (levels)
	);

	abtd_quant #(.SAMPLE_BITS(SAMPLE_BITS)) u_quant (
		.sample    (sample_value_s1),
		.accepted  (accepted),
		.tolerance (tolerance),
		.levels    (levels),
		.qres      (qres)
	);

	abtd_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.proc         (proc),
		.out_ready    (out_ready),
		.sample_valid (sample_valid_s1),
		.sample_value (sample_value_s1),
		.power_state  (power_state_s1),
		.ec_on        (ec_on_s1),
		.qres         (qres),
		.accepted     (accepted),
		.out_valid    (out_valid),
		.res          (res)
	);

	assign change_detected = res.change;
	assign hdd_removed     = res.removed[2];
	assign ssd_removed     = res.removed[1];
	assign bay_removed     = res.removed[0];
	assign hdd_present     = res.present[2];
	assign ssd_present     = res.present[1];
	assign bay_present     = res.present[0];

	// input stalls only with both registers full and the result held
	`ABTD_ASSERT_IMPL(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && out_valid && !out_ready, "in_ready low without a full pipe")
	// an input transfer always lands in the input register
	`ABTD_ASSERT_NEXT(a_in_lands, clk, arst_n, in_valid && in_ready, valid_s1, "input transfer lost")
	// disabled drives never report removal or presence
	`ABTD_ASSERT_IMPL(a_disabled_quiet, clk, arst_n, out_valid, (CHECK_SSD || (!ssd_removed && !ssd_present)) && (CHECK_BAY || (!bay_removed && !bay_present)), "disabled drive flagged")

endmodule

// ===== test/tb_adc_bay_tamper_detector.sv =====
// self-checking bench for adc_bay_tamper_detector: directed tick table, then randomized phases
// depends on abtd_pkg and the detector rtl; status is typed or predicted, then scoreboarded
`timescale 1ns / 1ps

module tb_adc_bay_tamper_detector;
	import abtd_pkg::*;

	localparam int SB          = SAMPLE_BITS_DEF;
	localparam int SMAX        = (1 << SB) - 1;
	localparam int PRESET_ROWS = 5;
	localparam int TABLE_ROWS  = 19;
	localparam int PHASES      = 8;
	localparam int PHASE_TICKS = 160;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam logic [1:0] PS_RESERVED = 2'd3;

	typedef enum int {
		CFG_DIRECTED, CFG_RANDOM, CFG_TOL_ZERO, CFG_TOL_MAX,
		CFG_LEVELS_MAX, CFG_LEVELS_ZERO, CFG_SCRAMBLED
	} cfg_plan_t;

	typedef struct packed {
		logic          sv;
		logic [SB-1:0] s;
		logic [1:0]    ps;
		logic          ec;
		logic          typed;
		result_t       want;
	} tick_t;

	localparam result_t QUIET    = '0;
	localparam result_t ACCEPTED = '{change: 1'b1, removed: 3'b000, present: 3'b000};

	// first rows run on reset config; the rest after the directed thresholds are loaded
	localparam tick_t DIRECTED [TABLE_ROWS] = '{
		'{1'b1, 10'd1023, PS_OTHER,    1'b1, 1'b1, QUIET},
		'{1'b1, 10'd0,    PS_S5,       1'b1, 1'b1, QUIET},
		'{1'b1, 10'd0,    PS_S5,       1'b1, 1'b1, ACCEPTED},  // zero tolerance
		'{1'b1, 10'd1023, PS_S5,       1'b0, 1'b1, QUIET},     // s5 with ec off
		'{1'b1, 10'd1023, PS_RESERVED, 1'b1, 1'b1, QUIET},
		'{1'b1, 10'd100,  PS_S5,       1'b1, 1'b0, QUIET},
		'{1'b1, 10'd100,  PS_S5,       1'b1, 1'b0, QUIET},
		'{1'b1, 10'd104,  PS_S5,       1'b1, 1'b0, QUIET},     // inside tolerance
		'{1'b1, 10'd650,  PS_S3,       1'b0, 1'b0, QUIET},
		'{1'b1, 10'd660,  PS_S3,       1'b0, 1'b0, QUIET},     // hdd pulled in s3
		'{1'b1, 10'd950,  PS_S3,       1'b0, 1'b0, QUIET},
		'{1'b1, 10'd450,  PS_S3,       1'b0, 1'b0, QUIET},     // second code differs
		'{1'b0, 10'd950,  PS_S3,       1'b0, 1'b0, QUIET},     // tick without sample
		'{1'b1, 10'd950,  PS_S3,       1'b0, 1'b0, QUIET},
		'{1'b1, 10'd1023, PS_S3,       1'b1, 1'b0, QUIET},
		'{1'b1, 10'd0,    PS_OTHER,    1'b0, 1'b0, QUIET},
		'{1'b1, 10'd0,    PS_RESERVED, 1'b1, 1'b0, QUIET},
		'{1'b1, 10'd0,    PS_S5,       1'b0, 1'b0, QUIET},
		'{1'b0, 10'd0,    PS_S5,       1'b1, 1'b0, QUIET}      // removed flags clear
	};

	localparam cfg_plan_t PLANS [PHASES] = '{
		CFG_RANDOM, CFG_TOL_ZERO, CFG_SCRAMBLED, CFG_TOL_MAX,
		CFG_LEVELS_MAX, CFG_RANDOM, CFG_LEVELS_ZERO, CFG_RANDOM
	};

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [SB-1:0]           cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    sample_valid;
	logic [SB-1:0]           sample_value;
	logic [1:0]              power_state;
	logic                    ec_on;
	logic                    out_valid;
	logic                    out_ready;
	logic                    change_detected;
	logic                    hdd_removed;
	logic                    ssd_removed;
	logic                    bay_removed;
	logic                    hdd_present;
	logic                    ssd_present;
	logic                    bay_present;

	// detector state and config as the bench tracks them
	logic [SB-1:0]        tol;
	logic [SB-1:0]        level [NUM_LEVELS];
	logic [SB-1:0]        acc_sample;
	logic [CODE_BITS-1:0] cur_code;
	logic [CODE_BITS-1:0] prev_code;
	logic [CODE_BITS-1:0] cand_code;
	logic                 code_pending;
	logic [CODE_BITS-1:0] removed_flags;

	result_t status_queue [$];
	int      errors;
	int      cycles;
	int      burst_left;
	int      stall_mode;
	int      stall_left;

	adc_bay_tamper_detector u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_valid    (sample_valid),
		.sample_value    (sample_value),
		.power_state     (power_state),
		.ec_on           (ec_on),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.change_detected (change_detected),
		.hdd_removed     (hdd_removed),
		.ssd_removed     (ssd_removed),
		.bay_removed     (bay_removed),
		.hdd_present     (hdd_present),
		.ssd_present     (ssd_present),
		.bay_present     (bay_present)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic result_t classify_tick(input logic sv, input logic [SB-1:0] s,
			input logic [1:0] ps, input logic ec);
		logic                 chg;
		logic [SB-1:0]        gap;
		logic [CODE_BITS-1:0] code;
		chg = 1'b0;
		if ((ps == PS_S5 && ec) || ps == PS_S3) begin
			gap = (s > acc_sample) ? s - acc_sample : acc_sample - s;
			if (!sv || gap < tol) begin
				code_pending = 1'b0;
			end else begin
				// lowest level index that the sample reaches wins
				code = CODE_BITS'(NUM_LEVELS);
				for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
					if (s >= level[k])
						code = CODE_BITS'(k);
				end
				if (code_pending) begin
					code_pending = 1'b0;
					if (cand_code == code) begin
						acc_sample = s;
						prev_code  = cur_code;
						cur_code   = cand_code;
						chg        = 1'b1;
					end
				end else begin
					cand_code    = code;
					code_pending = 1'b1;
				end
			end
			if (ps == PS_S5)
				removed_flags = '0;
			else if (chg)
				removed_flags |= prev_code & ~cur_code & ENABLED_MASK;
		end
		return '{change: chg, removed: removed_flags, present: cur_code & ENABLED_MASK};
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [SB-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_TOLERANCE)
			tol = val;
		else
			level[int'(idx) - int'(REG_LEVEL0)] = val;
	endtask

	task automatic load_config(input cfg_plan_t plan);
		logic [SB-1:0] v;
		case (plan)
			CFG_DIRECTED:   v = SB'(8);
			CFG_TOL_ZERO:   v = '0;
			CFG_TOL_MAX:    v = '1;
			default:        v = SB'($urandom_range(0, 40));
		endcase
		write_reg(REG_TOLERANCE, v);
		for (int k = 0; k < NUM_LEVELS; k++) begin
			case (plan)
				CFG_DIRECTED:    v = SB'(900 - 100 * k);
				CFG_LEVELS_MAX:  v = '1;
				CFG_LEVELS_ZERO: v = '0;
				CFG_SCRAMBLED:   v = SB'($urandom_range(0, SMAX));
				// descending bands so every code is reachable
				default:         v = SB'($urandom_range(SMAX - 128 * k, SMAX - 127 - 128 * k));
			endcase
			write_reg(cfg_reg_t'(int'(REG_LEVEL0) + k), v);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (status_queue.size() != 0)
			@(posedge clk);
	endtask

	// one transfer on the tick channel, then the burst/gap pacing of the sender
	task automatic issue_tick(input tick_t t);
		result_t p;
		in_valid     <= 1'b1;
		sample_valid <= t.sv;
		sample_value <= t.s;
		power_state  <= t.ps;
		ec_on        <= t.ec;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		p = classify_tick(t.sv, t.s, t.ps, t.ec);
		status_queue.push_back(t.typed ? t.want : p);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic report(input string why, input result_t want, input result_t got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0t %s: expected change %b removed %b present %b, got change %b removed %b present %b",
				$time, why, want.change, want.removed, want.present,
				got.change, got.removed, got.present);
	endtask

	// receiver side: status transfer compare
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{change: change_detected,
				removed: {hdd_removed, ssd_removed, bay_removed},
				present: {hdd_present, ssd_present, bay_present}};
			if (status_queue.size() == 0) begin
				report("status with none due", QUIET, got);
			end else begin
				want = status_queue.pop_front();
				if (got.change !== want.change || got.removed !== want.removed
						|| got.present !== want.present)
					report("status mismatch", want, got);
			end
		end
	end

	// receiver stalls: modes of always ready, light stalls and heavy stalls
	always @(posedge clk) begin
		if (stall_left <= 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(16, 96);
		end
		stall_left--;
		case (stall_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int            r;
		int            tmp;
		logic [1:0]    ps;
		logic          ec;
		logic          sv;
		logic [SB-1:0] s;
		logic [SB-1:0] last_s;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_TOLERANCE;
		cfg_data      = '0;
		in_valid      = 1'b0;
		sample_valid  = 1'b0;
		sample_value  = '0;
		power_state   = PS_OTHER;
		ec_on         = 1'b0;
		out_ready     = 1'b0;
		tol           = '0;
		for (int k = 0; k < NUM_LEVELS; k++)
			level[k] = '0;
		acc_sample    = '0;
		cur_code      = '0;
		prev_code     = '0;
		cand_code     = '0;
		code_pending  = 1'b0;
		removed_flags = '0;
		errors        = 0;
		cycles        = 0;
		stall_left    = 0;
		burst_left    = 1;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < TABLE_ROWS; i++) begin
			if (i == PRESET_ROWS) begin
				drain_results();
				load_config(CFG_DIRECTED);
			end
			issue_tick(DIRECTED[i]);
		end

		ps     = PS_S5;
		last_s = '0;
		for (int phase = 0; phase < PHASES; phase++) begin
			// config only changes with nothing in flight
			drain_results();
			load_config(PLANS[phase]);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// power state runs in stretches so debounce pairs land in one state
				if ($urandom_range(0, 9) == 0) begin
					r  = $urandom_range(0, 99);
					ps = (r < 45) ? PS_S3 : (r < 85) ? PS_S5 : (r < 93) ? PS_OTHER : PS_RESERVED;
				end
				ec = (ps == PS_S5) ? ($urandom_range(0, 6) != 0) : 1'($urandom_range(0, 1));
				r  = $urandom_range(0, 99);
				if (r < 45) begin
					tmp = int'(last_s) + int'($urandom_range(0, 6)) - 3;
					if (tmp < 0)
						tmp = 0;
					if (tmp > SMAX)
						tmp = SMAX;
					s = SB'(tmp);
				end else if (r < 55) begin
					s = (r < 50) ? '1 : '0;
				end else begin
					s = SB'($urandom_range(0, SMAX));
				end
				last_s = s;
				sv     = ($urandom_range(0, 9) != 0);
				issue_tick('{sv, s, ps, ec, 1'b0, QUIET});
			end
		end

		drain_results();
		repeat (12)
			@(posedge clk);
		if (errors == 0 && status_queue.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
